>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define CHECK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent is followed, in the next cycle, by a consequent.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/oale_pkg.sv
`timescale 1ns / 1ps

package oale_pkg;

  // List capacity and the index and count widths that follow from it.
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the request and result words.
  localparam int CMD_W    = 3;
  localparam int POS_W    = 3;
  localparam int ID_W     = 8;
  localparam int QTY_W    = 32;
  localparam int PRICE_W  = 32;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 3;
  localparam int COUNT_W  = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [POS_W-1:0]          position;
    logic [ID_W-1:0]           key;
    logic signed [QTY_W-1:0]   quantity;
    logic signed [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]         size_code;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   found_index;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_word_t;

  // One stored list entry.
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [QTY_W-1:0]   quantity;
    logic signed [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]         size_code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/ordered_array_list_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ordered list of up to oale_pkg::DEPTH entries kept in one RAM. A command word
// is taken when start is high and busy is low; exactly one result word follows,
// shown on result for a single cycle while done is high, and the receiver
// cannot stall it. Inserts at the end, a front insert into an empty list, rejected
// commands and unused codes answer in the cycle after acceptance. Search, update
// and remove walk the list one entry a cycle from slot 0, and remove then closes
// the gap one entry a cycle; insert at the front or at a position moves the tail
// up one entry a cycle. The single RAM read port, read once per cycle, sets this
// pace. busy is high for the whole walk.
module ordered_array_list_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  oale_pkg::req_word_t request,
  output logic                done,
  output oale_pkg::rsp_word_t result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_FILL,
    ST_SEARCH,
    ST_SHIFT_DN
  } state_t;

  state_t                          state;
  oale_pkg::req_word_t             req;
  logic [oale_pkg::CNT_W-1:0]      len;
  logic [oale_pkg::IDX_W-1:0]      idx;
  logic [oale_pkg::IDX_W-1:0]      tgt;

  logic                            ram_we;
  logic [oale_pkg::IDX_W-1:0]      ram_waddr;
  oale_pkg::entry_t                ram_wdata;
  logic [oale_pkg::IDX_W-1:0]      ram_raddr;
  oale_pkg::entry_t                ram_rdata;

  logic                            full;
  logic                            match;
  logic                            last;

  oale_ram #(
    .WIDTH(oale_pkg::ENTRY_W),
    .DEPTH(oale_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy  = (state != ST_IDLE);
  assign full  = (len == oale_pkg::CNT_W'(oale_pkg::DEPTH));
  assign match = (ram_rdata.id == req.key);
  // The entry now read out is the last one of the list.
  assign last  = ((oale_pkg::CNT_W'(idx) + oale_pkg::CNT_W'(1)) == len);

  // RAM port control: read address for the next step and the write of this one.
  always_comb begin
    ram_we              = 1'b0;
    ram_waddr           = idx;
    ram_raddr           = idx;
    ram_wdata.id        = req.key;
    ram_wdata.quantity  = req.quantity;
    ram_wdata.price     = req.price;
    ram_wdata.size_code = req.size_code;
    unique case (state)
      ST_IDLE: begin
        ram_wdata.quantity  = request.quantity;
        ram_wdata.price     = request.price;
        ram_wdata.size_code = request.size_code;
        ram_wdata.id        = oale_pkg::ID_W'(len);
        ram_waddr           = oale_pkg::IDX_W'(len);
        if (request.cmd == oale_pkg::CMD_INS_FRONT || request.cmd == oale_pkg::CMD_INS_POS) begin
          ram_raddr = oale_pkg::IDX_W'(len - oale_pkg::CNT_W'(1));
        end else begin
          ram_raddr = '0;
        end
        // Append, or a front insert into an empty list, writes in one go.
        if (start && !full && (request.cmd == oale_pkg::CMD_INS_END ||
            (request.cmd == oale_pkg::CMD_INS_FRONT && len == '0))) begin
          ram_we = 1'b1;
        end
      end
      ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = oale_pkg::IDX_W'(idx + 1'b1);
        ram_wdata = ram_rdata;
        ram_raddr = oale_pkg::IDX_W'(idx - 1'b1);
      end
      ST_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = tgt;
        ram_wdata.id = oale_pkg::ID_W'(tgt);
      end
      ST_SEARCH: begin
        ram_raddr = oale_pkg::IDX_W'(idx + 1'b1);
        if (match && req.cmd == oale_pkg::CMD_UPDATE) begin
          ram_we       = 1'b1;
          ram_waddr    = idx;
          ram_wdata.id = ram_rdata.id;
        end
      end
      ST_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = oale_pkg::IDX_W'(idx - 1'b1);
        ram_wdata = ram_rdata;
        ram_raddr = oale_pkg::IDX_W'(idx + 1'b1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer: state, list length and the registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req                <= request;
            idx                <= '0;
            result.status      <= oale_pkg::STAT_OK;
            result.found_index <= '0;
            result.entry_count <= oale_pkg::COUNT_W'(len);
            unique case (request.cmd) inside
              oale_pkg::CMD_INS_FRONT, oale_pkg::CMD_INS_POS: begin
                if (full) begin
                  result.status <= oale_pkg::STAT_FULL;
                  done          <= 1'b1;
                end else if (request.cmd == oale_pkg::CMD_INS_POS &&
                             oale_pkg::CNT_W'(request.position) >= len) begin
                  result.status <= oale_pkg::STAT_BADPOS;
                  done          <= 1'b1;
                end else if (len == '0) begin
                  len                <= len + oale_pkg::CNT_W'(1);
                  result.entry_count <= oale_pkg::COUNT_W'(len + oale_pkg::CNT_W'(1));
                  done               <= 1'b1;
                end else begin
                  idx   <= oale_pkg::IDX_W'(len - oale_pkg::CNT_W'(1));
                  tgt   <= (request.cmd == oale_pkg::CMD_INS_POS) ?
                           oale_pkg::IDX_W'(request.position) : '0;
                  state <= ST_SHIFT_UP;
                end
              end
              oale_pkg::CMD_INS_END: begin
                if (full) begin
                  result.status <= oale_pkg::STAT_FULL;
                end else begin
                  len                <= len + oale_pkg::CNT_W'(1);
                  result.entry_count <= oale_pkg::COUNT_W'(len + oale_pkg::CNT_W'(1));
                end
                done <= 1'b1;
              end
              oale_pkg::CMD_REMOVE, oale_pkg::CMD_UPDATE, oale_pkg::CMD_SEARCH: begin
                if (len == '0) begin
                  result.status <= (request.cmd == oale_pkg::CMD_SEARCH) ?
                                   oale_pkg::STAT_NOTFOUND : oale_pkg::STAT_EMPTY;
                  done          <= 1'b1;
                end else begin
                  state <= ST_SEARCH;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SHIFT_UP: begin
          if (idx == tgt) begin
            state <= ST_FILL;
          end else begin
            idx <= oale_pkg::IDX_W'(idx - 1'b1);
          end
        end
        ST_FILL: begin
          len                <= len + oale_pkg::CNT_W'(1);
          result.entry_count <= oale_pkg::COUNT_W'(len + oale_pkg::CNT_W'(1));
          done               <= 1'b1;
          state              <= ST_IDLE;
        end
        ST_SEARCH: begin
          if (match) begin
            if (req.cmd == oale_pkg::CMD_SEARCH) begin
              result.found_index <= oale_pkg::FIDX_W'(idx);
              done               <= 1'b1;
              state              <= ST_IDLE;
            end else if (req.cmd == oale_pkg::CMD_UPDATE) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end else if (last) begin
              len                <= len - oale_pkg::CNT_W'(1);
              result.entry_count <= oale_pkg::COUNT_W'(len - oale_pkg::CNT_W'(1));
              done               <= 1'b1;
              state              <= ST_IDLE;
            end else begin
              idx   <= oale_pkg::IDX_W'(idx + 1'b1);
              state <= ST_SHIFT_DN;
            end
          end else if (last) begin
            result.status <= oale_pkg::STAT_NOTFOUND;
            done          <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            idx <= oale_pkg::IDX_W'(idx + 1'b1);
          end
        end
        ST_SHIFT_DN: begin
          if (last) begin
            len                <= len - oale_pkg::CNT_W'(1);
            result.entry_count <= oale_pkg::COUNT_W'(len - oale_pkg::CNT_W'(1));
            done               <= 1'b1;
            state              <= ST_IDLE;
          end else begin
            idx <= oale_pkg::IDX_W'(idx + 1'b1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result word only appears once the sequencer is back in idle.
  `CHECK_CLK(a_done_idle, !done || state == ST_IDLE, "result word while sequencer busy")
  // The list never grows beyond its capacity.
  `CHECK_CLK(a_len_cap, len <= oale_pkg::CNT_W'(oale_pkg::DEPTH), "list length over capacity")
  // Writes stay inside the list or the slot just past its end.
  `CHECK_CLK(a_write_range,
             !ram_we || oale_pkg::CNT_W'(ram_waddr) <= len,
             "RAM write beyond list end")
  // An append to a full list answers next cycle with the full status.
  `CHECK_NEXT(a_full_append,
              start && !busy && full && request.cmd == oale_pkg::CMD_INS_END,
              done && result.status == oale_pkg::STAT_FULL,
              "append on full list not rejected")

endmodule

>>> sv/oale_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module oale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Command codes that the block does not use; it answers them with an unchanged list.
  localparam logic [oale_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [oale_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 1325;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * oale_pkg::DEPTH + 8;

  // A directed row may carry a response typed in by hand.
  typedef struct {
    oale_pkg::req_word_t word;
    bit                  typed;
    oale_pkg::rsp_word_t response;
  } plan_row_t;

  typedef struct {
    bit                  typed;
    oale_pkg::rsp_word_t response;
  } row_check_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  oale_pkg::req_word_t request;
  logic                done;
  oale_pkg::rsp_word_t result;

  ordered_array_list_engine uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list, advanced once for every accepted command word.
  oale_pkg::entry_t list_shadow [oale_pkg::DEPTH];
  int               list_count;

  oale_pkg::rsp_word_t expected_responses [$];
  row_check_t          row_checks [$];
  plan_row_t           directed_plan [$];
  int                  mismatch_count;
  int                  quiet_cycles;
  oale_pkg::rsp_word_t want;
  row_check_t          check_now;

  // Works out the response to one command word and updates the shadow list.
  function automatic oale_pkg::rsp_word_t predict_list_response(input oale_pkg::req_word_t w);
    oale_pkg::rsp_word_t r;
    oale_pkg::entry_t    e;
    int                  hit;
    int                  i;
    r.status      = oale_pkg::STAT_OK;
    r.found_index = '0;
    e.id          = '0;
    e.quantity    = w.quantity;
    e.price       = w.price;
    e.size_code   = w.size_code;
    hit = -1;
    for (i = 0; i < list_count; i++) begin
      if (hit < 0 && list_shadow[i].id == w.key) begin
        hit = i;
      end
    end
    case (w.cmd)
      oale_pkg::CMD_INS_FRONT: begin
        if (list_count >= oale_pkg::DEPTH) begin
          r.status = oale_pkg::STAT_FULL;
        end else begin
          for (i = list_count; i > 0; i--) list_shadow[i] = list_shadow[i-1];
          list_shadow[0] = e;
          list_count++;
        end
      end
      oale_pkg::CMD_INS_END: begin
        if (list_count >= oale_pkg::DEPTH) begin
          r.status = oale_pkg::STAT_FULL;
        end else begin
          e.id = oale_pkg::ID_W'(list_count);
          list_shadow[list_count] = e;
          list_count++;
        end
      end
      oale_pkg::CMD_INS_POS: begin
        if (list_count >= oale_pkg::DEPTH) begin
          r.status = oale_pkg::STAT_FULL;
        end else if (int'(w.position) >= list_count) begin
          r.status = oale_pkg::STAT_BADPOS;
        end else begin
          for (i = list_count; i > int'(w.position); i--) list_shadow[i] = list_shadow[i-1];
          e.id = oale_pkg::ID_W'(w.position);
          list_shadow[w.position] = e;
          list_count++;
        end
      end
      oale_pkg::CMD_REMOVE: begin
        if (list_count == 0) begin
          r.status = oale_pkg::STAT_EMPTY;
        end else if (hit < 0) begin
          r.status = oale_pkg::STAT_NOTFOUND;
        end else begin
          for (i = hit; i < list_count - 1; i++) list_shadow[i] = list_shadow[i+1];
          list_count--;
        end
      end
      oale_pkg::CMD_SEARCH: begin
        if (hit < 0) begin
          r.status = oale_pkg::STAT_NOTFOUND;
        end else begin
          r.found_index = oale_pkg::FIDX_W'(hit);
        end
      end
      oale_pkg::CMD_UPDATE: begin
        if (list_count == 0) begin
          r.status = oale_pkg::STAT_EMPTY;
        end else if (hit < 0) begin
          r.status = oale_pkg::STAT_NOTFOUND;
        end else begin
          list_shadow[hit].quantity  = w.quantity;
          list_shadow[hit].price     = w.price;
          list_shadow[hit].size_code = w.size_code;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = oale_pkg::COUNT_W'(list_count);
    return r;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  // Accepted command words are predicted; result words are checked against the oldest one.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        check_now = row_checks.pop_front();
        want = predict_list_response(request);
        if (check_now.typed) begin
          want = check_now.response;
        end
        expected_responses.push_back(want);
      end
      if (done) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("result word with nothing pending, status", int'(result.status), 0);
        end else begin
          want = expected_responses.pop_front();
          if (result.status !== want.status) begin
            report_mismatch("status", int'(result.status), int'(want.status));
          end
          if (result.found_index !== want.found_index) begin
            report_mismatch("found_index", int'(result.found_index), int'(want.found_index));
          end
          if (result.entry_count !== want.entry_count) begin
            report_mismatch("entry_count", int'(result.entry_count), int'(want.entry_count));
          end
        end
      end
    end
  end

  // Ends the run when nothing moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ordered_array_list_engine test failed");
        $finish;
      end
    end
  end

  // Offers one command word and holds it until the block takes it.
  task automatic send_word(input oale_pkg::req_word_t w, input bit typed,
                           input oale_pkg::rsp_word_t rsp);
    row_check_t c;
    c.typed    = typed;
    c.response = rsp;
    row_checks.push_back(c);
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // One cycle with start low and random noise on the request word.
  task automatic idle_cycle();
    oale_pkg::req_word_t noise;
    noise.cmd       = oale_pkg::CMD_W'($urandom_range(7));
    noise.position  = oale_pkg::POS_W'($urandom_range(7));
    noise.key       = oale_pkg::ID_W'($urandom_range(255));
    noise.quantity  = $urandom;
    noise.price     = $urandom;
    noise.size_code = oale_pkg::SIZE_W'($urandom_range(255));
    start   <= 1'b0;
    request <= noise;
    @(posedge clk);
  endtask

  // Holds off until every pending result word has come back.
  task automatic wait_for_drain();
    idle_cycle();
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic plan_row(input logic [oale_pkg::CMD_W-1:0] cmd, input int pos, input int key,
                          input logic [31:0] qty, input logic [31:0] prc, input int sz,
                          input int typed, input logic [oale_pkg::STATUS_W-1:0] st,
                          input int cnt);
    plan_row_t row;
    row.word.cmd              = cmd;
    row.word.position         = oale_pkg::POS_W'(pos);
    row.word.key              = oale_pkg::ID_W'(key);
    row.word.quantity         = qty;
    row.word.price            = prc;
    row.word.size_code        = oale_pkg::SIZE_W'(sz);
    row.typed                 = (typed != 0);
    row.response.status       = st;
    row.response.found_index  = '0;
    row.response.entry_count  = oale_pkg::COUNT_W'(cnt);
    directed_plan.push_back(row);
  endtask

  // Random field values, with the signed extremes showing up now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Builds one random command word; filling leans toward inserts, draining toward removes.
  function automatic oale_pkg::req_word_t make_random_word(input bit filling);
    oale_pkg::req_word_t w;
    int                  roll;
    int                  pick;
    roll = $urandom_range(99);
    pick = $urandom_range(2);
    if (roll < 2) begin
      w.cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (roll < (filling ? 65 : 30)) begin
      w.cmd = (pick == 0) ? oale_pkg::CMD_INS_FRONT :
              (pick == 1) ? oale_pkg::CMD_INS_END : oale_pkg::CMD_INS_POS;
    end else if (!filling && roll < 70) begin
      w.cmd = oale_pkg::CMD_REMOVE;
    end else begin
      w.cmd = (pick == 0) ? oale_pkg::CMD_REMOVE :
              (pick == 1) ? oale_pkg::CMD_SEARCH : oale_pkg::CMD_UPDATE;
    end
    w.position  = oale_pkg::POS_W'($urandom_range(7));
    w.key       = ($urandom_range(99) < 85) ? oale_pkg::ID_W'($urandom_range(oale_pkg::DEPTH))
                                            : oale_pkg::ID_W'($urandom_range(255));
    w.quantity  = pick_value();
    w.price     = pick_value();
    w.size_code = oale_pkg::SIZE_W'($urandom_range(255));
    return w;
  endfunction

  initial begin
    int                  idle_pct [4];
    int                  phase;
    int                  counted;
    int                  gap;
    bit                  filling;
    oale_pkg::req_word_t w;
    oale_pkg::rsp_word_t none;

    idle_pct = '{0, 64, 16, 0};
    none = '0;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    list_count = 0;
    for (int i = 0; i < oale_pkg::DEPTH; i++) list_shadow[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list cases, the signed extremes, filling up, full list cases, the unused codes.
    plan_row(oale_pkg::CMD_INS_FRONT == 3'd0 ? oale_pkg::CMD_SEARCH : oale_pkg::CMD_SEARCH,
             0, 0, 32'h0, 32'h0, 0, 1, oale_pkg::STAT_NOTFOUND, 0);
    plan_row(oale_pkg::CMD_REMOVE,    0, 0,   32'h0, 32'h0, 0,   1, oale_pkg::STAT_EMPTY,  0);
    plan_row(oale_pkg::CMD_UPDATE,    0, 0,   32'h1, 32'h1, 1,   1, oale_pkg::STAT_EMPTY,  0);
    plan_row(oale_pkg::CMD_INS_POS,   0, 0,   32'h0, 32'h0, 0,   1, oale_pkg::STAT_BADPOS, 0);
    plan_row(oale_pkg::CMD_INS_END,   7, 255, 32'h7fff_ffff, 32'h8000_0000, 255,
             1, oale_pkg::STAT_OK, 1);
    plan_row(oale_pkg::CMD_INS_FRONT, 0, 0,   32'h8000_0000, 32'h7fff_ffff, 0,
             1, oale_pkg::STAT_OK, 2);
    plan_row(oale_pkg::CMD_INS_POS,   1, 0,   32'h0, 32'h0, 'h55, 1, oale_pkg::STAT_OK, 3);
    plan_row(oale_pkg::CMD_INS_POS,   3, 0,   32'h5, 32'h6, 7,   1, oale_pkg::STAT_BADPOS, 3);
    plan_row(oale_pkg::CMD_INS_POS,   2, 9,   32'h1234_5678, 32'hfedc_ba98, 'hc3,
             0, oale_pkg::STAT_OK, 0);
    for (int i = 0; i < 4; i++) begin
      plan_row(oale_pkg::CMD_INS_END, 0, 0, $urandom, $urandom, $urandom_range(255),
               0, oale_pkg::STAT_OK, 0);
    end
    plan_row(oale_pkg::CMD_INS_FRONT, 0, 0,   32'h1, 32'h1, 1,   1, oale_pkg::STAT_FULL, 8);
    plan_row(oale_pkg::CMD_INS_END,   0, 0,   32'h1, 32'h1, 1,   1, oale_pkg::STAT_FULL, 8);
    plan_row(oale_pkg::CMD_INS_POS,   7, 0,   32'h1, 32'h1, 1,   1, oale_pkg::STAT_FULL, 8);
    plan_row(oale_pkg::CMD_SEARCH,    0, 7,   32'h0, 32'h0, 0,   0, oale_pkg::STAT_OK,   0);
    plan_row(oale_pkg::CMD_SEARCH,    0, 255, 32'h0, 32'h0, 0,   1, oale_pkg::STAT_NOTFOUND, 8);
    plan_row(oale_pkg::CMD_UPDATE,    0, 0,   32'hffff_ffff, 32'h1, 'haa,
             0, oale_pkg::STAT_OK, 0);
    plan_row(oale_pkg::CMD_UPDATE,    0, 200, 32'h0, 32'h0, 0,   1, oale_pkg::STAT_NOTFOUND, 8);
    plan_row(oale_pkg::CMD_REMOVE,    0, 0,   32'h0, 32'h0, 0,   0, oale_pkg::STAT_OK,   0);
    plan_row(oale_pkg::CMD_REMOVE,    0, 255, 32'h0, 32'h0, 0,   1, oale_pkg::STAT_NOTFOUND, 7);
    plan_row(CMD_SPARE_LO,            5, 3,   32'h0, 32'h0, 0,   0, oale_pkg::STAT_OK,   0);
    plan_row(CMD_SPARE_HI,            7, 255, 32'hffff_ffff, 32'hffff_ffff, 255,
             0, oale_pkg::STAT_OK, 0);
    plan_row(oale_pkg::CMD_SEARCH,    0, 1,   32'h0, 32'h0, 0,   0, oale_pkg::STAT_OK,   0);

    foreach (directed_plan[i]) begin
      send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].response);
    end

    // Random part in phases of sender idling, with a full drain between phases.
    counted = 0;
    filling = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      wait_for_drain();
      while (counted < (RANDOM_ITEMS * (phase + 1)) / 4) begin
        if (counted % 12 == 0) begin
          filling = ($urandom_range(1) != 0);
        end
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct[phase]) begin
          idle_cycle();
          gap++;
        end
        w = make_random_word(filling);
        send_word(w, 1'b0, none);
        if (w.cmd <= oale_pkg::CMD_UPDATE) begin
          counted++;
        end
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ordered_array_list_engine test passed");
    end else begin
      $display("ordered_array_list_engine test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/oale_pkg.sv
sv/oale_ram.sv
sv/ordered_array_list_engine.sv
verif/tb_top.sv
